// ===== src/nes_pkg.sv =====
`default_nettype none
package nes_pkg;

  localparam int ELEM_W = 16;
  localparam int DIST_W = 20;
  localparam int SUM_W  = 2 * DIST_W + 1;
  localparam logic [SUM_W-1:0] SUM_CAP = {1'b1, {(SUM_W-1){1'b0}}};

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [2:0] ST_ADDED   = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_MATCH   = 3'd2;
  localparam logic [2:0] ST_EMPTY   = 3'd3;
  localparam logic [2:0] ST_LENERR  = 3'd4;
  localparam logic [2:0] ST_CLEARED = 3'd5;

  typedef struct packed {
    logic [1:0]               op;
    logic signed [ELEM_W-1:0] vector_element;
    logic                     last;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [5:0]        match_index;
    logic [DIST_W-1:0] distance;
    logic [6:0]        stored_count;
  } out_item_t;

  // One unit of work handed from the front to the back.
  typedef struct packed {
    logic       search;
    logic [2:0] status;
    logic [6:0] count;
  } job_t;

  typedef struct packed {
    logic busy;
    logic search_done;
  } back_status_t;

endpackage
`default_nettype wire

// ===== src/nes_ram.sv =====
`default_nettype none
module nes_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/nes_fifo.sv =====
`default_nettype none
module nes_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire nes_pkg::job_t din,
  output logic        full,
  input  wire logic   pop,
  output nes_pkg::job_t dout,
  output logic        empty
);
  import nes_pkg::*;

  localparam int PW = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push && !full) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : PW'(wp_r + 1'b1);
      end
      if (pop && !empty) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : PW'(rp_r + 1'b1);
      end
      if ((push && !full) && !(pop && !empty)) begin
        cnt_r <= CW'(cnt_r + 1'b1);
      end else if (!(push && !full) && (pop && !empty)) begin
        cnt_r <= CW'(cnt_r - 1'b1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/nes_front.sv =====
`default_nettype none
module nes_front #(
  parameter int MAX_ENTRIES = 64,
  parameter int EMBED_DIM   = 128
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_push,
  input  wire nes_pkg::in_item_t    in_item,
  output logic                      in_full,
  output logic                      job_push,
  output nes_pkg::job_t             job,
  input  wire logic                 job_full,
  input  wire nes_pkg::back_status_t bstat,
  output logic                      entry_we,
  output logic [(MAX_ENTRIES * EMBED_DIM > 1 ? $clog2(MAX_ENTRIES * EMBED_DIM) : 1)-1:0]
                                    entry_waddr,
  output logic [nes_pkg::ELEM_W-1:0] entry_wdata,
  output logic                      query_we,
  output logic [(EMBED_DIM > 1 ? $clog2(EMBED_DIM) : 1)-1:0] query_waddr,
  output logic [nes_pkg::ELEM_W-1:0] query_wdata,
  output logic [$clog2(MAX_ENTRIES + 1)-1:0] count
);
  import nes_pkg::*;

  localparam int COL_W = EMBED_DIM > 1 ? $clog2(EMBED_DIM) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int AW    = MAX_ENTRIES * EMBED_DIM > 1 ? $clog2(MAX_ENTRIES * EMBED_DIM) : 1;

  logic [COL_W-1:0] pos_r, pos_nxt;
  logic             kind_r, kind_nxt;  // 1 while a query vector is in progress
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [AW-1:0]    wbase_r, wbase_nxt;
  logic             wait_r, wait_nxt;
  logic             accept, is_query, pos_last, store_full;

  assign in_full     = job_full || wait_r;
  assign accept      = in_push && !in_full;
  assign is_query    = (in_item.op == OP_QUERY);
  assign pos_last    = (pos_r == COL_W'(EMBED_DIM - 1));
  assign store_full  = (count_r >= CNT_W'(MAX_ENTRIES));
  assign entry_waddr = wbase_r + AW'(pos_r);
  assign entry_wdata = in_item.vector_element;
  assign query_waddr = pos_r;
  assign query_wdata = in_item.vector_element;
  assign count       = count_r;

  always_comb begin
    pos_nxt   = pos_r;
    kind_nxt  = kind_r;
    count_nxt = count_r;
    wbase_nxt = wbase_r;
    wait_nxt  = wait_r;
    job_push  = 1'b0;
    job       = '0;
    entry_we  = 1'b0;
    query_we  = 1'b0;
    if (bstat.search_done) begin
      wait_nxt = 1'b0;
    end
    if (accept) begin
      case (in_item.op)
        OP_CLEAR: begin
          pos_nxt    = '0;
          count_nxt  = '0;
          wbase_nxt  = '0;
          job_push   = 1'b1;
          job.status = ST_CLEARED;
        end
        OP_ADD, OP_QUERY: begin
          if (((pos_r != '0) && (is_query != kind_r)) || (in_item.last != pos_last)) begin
            pos_nxt    = '0;
            job_push   = 1'b1;
            job.status = ST_LENERR;
            job.count  = 7'(count_r);
          end else begin
            kind_nxt = is_query;
            entry_we = !is_query && !store_full;
            query_we = is_query;
            if (!in_item.last) begin
              pos_nxt = COL_W'(pos_r + 1'b1);
            end else begin
              pos_nxt  = '0;
              job_push = 1'b1;
              if (!is_query) begin
                if (store_full) begin
                  job.status = ST_FULL;
                  job.count  = 7'(count_r);
                end else begin
                  count_nxt  = CNT_W'(count_r + 1'b1);
                  wbase_nxt  = wbase_r + AW'(EMBED_DIM);
                  job.status = ST_ADDED;
                  job.count  = 7'(count_r + 1'b1);
                end
              end else if (count_r == '0) begin
                job.status = ST_EMPTY;
                job.count  = 7'(count_r);
              end else begin
                job.search = 1'b1;
                job.status = ST_MATCH;
                job.count  = 7'(count_r);
                wait_nxt   = 1'b1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      kind_r  <= 1'b0;
      count_r <= '0;
      wbase_r <= '0;
      wait_r  <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      kind_r  <= kind_nxt;
      count_r <= count_nxt;
      wbase_r <= wbase_nxt;
      wait_r  <= wait_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/nes_back.sv =====
`default_nettype none
module nes_back #(
  parameter int MAX_ENTRIES = 64,
  parameter int EMBED_DIM   = 128
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 job_empty,
  input  wire nes_pkg::job_t        job,
  output logic                      job_pop,
  input  wire logic [$clog2(MAX_ENTRIES + 1)-1:0] count,
  output logic [(MAX_ENTRIES * EMBED_DIM > 1 ? $clog2(MAX_ENTRIES * EMBED_DIM) : 1)-1:0]
                                    entry_raddr,
  input  wire logic [nes_pkg::ELEM_W-1:0] entry_rdata,
  output logic [(EMBED_DIM > 1 ? $clog2(EMBED_DIM) : 1)-1:0] query_raddr,
  input  wire logic [nes_pkg::ELEM_W-1:0] query_rdata,
  output nes_pkg::out_item_t        out_item,
  output logic                      out_empty,
  input  wire logic                 out_pop,
  output nes_pkg::back_status_t     bstat
);
  import nes_pkg::*;

  localparam int COL_W = EMBED_DIM > 1 ? $clog2(EMBED_DIM) : 1;
  localparam int ROW_W = MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int AW    = MAX_ENTRIES * EMBED_DIM > 1 ? $clog2(MAX_ENTRIES * EMBED_DIM) : 1;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_SQRT, S_DONE} state_t;

  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last_col;
    logic             last;
    logic [ROW_W-1:0] row;
  } tag_t;

  state_t           state_r, state_nxt;
  logic             issue_r, issue_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [AW-1:0]    base_r, base_nxt;
  logic [SUM_W-1:0] acc_r, best_r, best_nxt;
  logic [ROW_W-1:0] best_idx_r, best_idx_nxt;
  logic [2*DIST_W-1:0] n_sh_r, n_sh_nxt;
  logic [DIST_W+1:0]   rem_r, rem_nxt;
  logic [DIST_W-1:0]   root_r, root_nxt;
  logic [4:0]       step_r, step_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;
  logic             done_r, done_nxt;

  tag_t             tag0, p1_r, p2_r, p3_r;
  logic signed [ELEM_W:0]     diff_r;
  logic signed [2*ELEM_W+1:0] prod;
  logic [2*ELEM_W-1:0]        sq_r;
  logic [SUM_W:0]   sum_raw;
  logic [SUM_W-1:0] sum_sat, acc_base;
  logic             last_col, last_row, out_free, take;
  logic [DIST_W+3:0] rem_sh, trial;

  assign out_free    = !out_valid_r || out_pop;
  assign out_empty   = !out_valid_r;
  assign out_item    = out_item_r;
  assign bstat.busy        = (state_r != S_IDLE);
  assign bstat.search_done = done_r;

  assign last_col    = (col_r == COL_W'(EMBED_DIM - 1));
  assign last_row    = (CNT_W'(row_r) == count - CNT_W'(1));
  assign entry_raddr = base_r + AW'(col_r);
  assign query_raddr = col_r;

  always_comb begin
    tag0.valid    = issue_r;
    tag0.first    = (col_r == '0);
    tag0.last_col = last_col;
    tag0.last     = last_col && last_row;
    tag0.row      = row_r;
  end

  // Squared-difference pipeline: RAM read, subtract, multiply, accumulate.
  assign prod = diff_r * diff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r.valid <= 1'b0;
      p2_r.valid <= 1'b0;
      p3_r.valid <= 1'b0;
    end else begin
      p1_r <= tag0;
      p2_r <= p1_r;
      p3_r <= p2_r;
    end
    diff_r <= $signed({query_rdata[ELEM_W-1], query_rdata})
            - $signed({entry_rdata[ELEM_W-1], entry_rdata});
    sq_r   <= prod[2*ELEM_W-1:0];
    if (p3_r.valid) begin
      acc_r <= sum_sat;
    end
  end

  always_comb begin
    acc_base = p3_r.first ? '0 : acc_r;
    sum_raw  = {1'b0, acc_base} + (SUM_W + 1)'(sq_r);
    sum_sat  = (sum_raw >= {1'b0, SUM_CAP}) ? SUM_CAP : sum_raw[SUM_W-1:0];
    take     = (p3_r.row == '0) || (sum_sat < best_r);
    best_nxt     = best_r;
    best_idx_nxt = best_idx_r;
    if (p3_r.valid && p3_r.last_col && take) begin
      best_nxt     = sum_sat;
      best_idx_nxt = p3_r.row;
    end
  end

  // One root bit per step, two radicand bits shifted in each time.
  assign rem_sh = {rem_r, n_sh_r[2*DIST_W-1 -: 2]};
  assign trial  = {2'b00, root_r, 2'b01};

  always_comb begin
    state_nxt     = state_r;
    issue_nxt     = issue_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    base_nxt      = base_r;
    n_sh_nxt      = n_sh_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_pop;
    out_item_nxt  = out_item_r;
    done_nxt      = 1'b0;
    job_pop       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (!job_empty) begin
          if (job.search) begin
            job_pop   = 1'b1;
            state_nxt = S_RUN;
            issue_nxt = 1'b1;
            row_nxt   = '0;
            col_nxt   = '0;
            base_nxt  = '0;
          end else if (out_free) begin
            job_pop       = 1'b1;
            out_valid_nxt = 1'b1;
            out_item_nxt.status       = job.status;
            out_item_nxt.match_index  = '0;
            out_item_nxt.distance     = (job.status == ST_EMPTY) ? '1 : '0;
            out_item_nxt.stored_count = job.count;
          end
        end
      end
      S_RUN: begin
        if (issue_r) begin
          if (last_col) begin
            col_nxt  = '0;
            base_nxt = base_r + AW'(EMBED_DIM);
            if (last_row) begin
              issue_nxt = 1'b0;
            end else begin
              row_nxt = ROW_W'(row_r + 1'b1);
            end
          end else begin
            col_nxt = COL_W'(col_r + 1'b1);
          end
        end
        if (p3_r.valid && p3_r.last) begin
          n_sh_nxt = best_nxt[2*DIST_W-1:0];
          rem_nxt  = '0;
          root_nxt = '0;
          step_nxt = '0;
          if (best_nxt[SUM_W-1]) begin
            root_nxt  = '1;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SQRT;
          end
        end
      end
      S_SQRT: begin
        n_sh_nxt = {n_sh_r[2*DIST_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_nxt  = (DIST_W + 2)'(rem_sh - trial);
          root_nxt = {root_r[DIST_W-2:0], 1'b1};
        end else begin
          rem_nxt  = rem_sh[DIST_W+1:0];
          root_nxt = {root_r[DIST_W-2:0], 1'b0};
        end
        step_nxt = 5'(step_r + 1'b1);
        if (step_r == 5'(DIST_W - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_item_nxt.status       = ST_MATCH;
          out_item_nxt.match_index  = 6'(best_idx_r);
          out_item_nxt.distance     = root_r;
          out_item_nxt.stored_count = 7'(count);
          done_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issue_r     <= 1'b0;
      out_valid_r <= 1'b0;
      done_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issue_r     <= issue_nxt;
      out_valid_r <= out_valid_nxt;
      done_r      <= done_nxt;
    end
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    base_r     <= base_nxt;
    best_r     <= best_nxt;
    best_idx_r <= best_idx_nxt;
    n_sh_r     <= n_sh_nxt;
    rem_r      <= rem_nxt;
    root_r     <= root_nxt;
    step_r     <= step_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule
`default_nettype wire

// ===== src/nearest_embedding_search.sv =====
// Nearest embedding search.
// Input channel (in_push / in_full / in_item): one vector element per request,
// op selects add, query or clear; the last flag marks element EMBED_DIM-1.
// Result channel (out_empty / out_pop / out_item): at most one result per
// request, in request order; the oldest result waits on out_item while
// out_empty is low.
// Add and query elements are taken one per cycle while in_full is low. A
// finished add, a clear or a length error passes through the job queue into
// the result register. A query on a non-empty store walks every stored
// element through one subtract-multiply-accumulate pipeline, one element a
// cycle, then takes a 20-step square root unless the best sum saturates;
// in_full stays high from its last element until after its result is loaded.
// Synchronous reset (rst_n low) empties the store and drops every pending
// result; the vector memories themselves are not cleared.
// When the receiver holds off pop, the result register and a four-deep job
// queue keep taking requests until the queue fills, then in_full rises.
`default_nettype none
module nearest_embedding_search #(
  parameter int MAX_ENTRIES = 64,
  parameter int EMBED_DIM   = 128
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_push,
  input  wire nes_pkg::in_item_t in_item,
  output logic                in_full,
  input  wire logic           out_pop,
  output nes_pkg::out_item_t  out_item,
  output logic                out_empty
);
  import nes_pkg::*;

  localparam int COL_W = EMBED_DIM > 1 ? $clog2(EMBED_DIM) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int AW    = MAX_ENTRIES * EMBED_DIM > 1 ? $clog2(MAX_ENTRIES * EMBED_DIM) : 1;

  logic              job_push, job_full, job_pop, job_empty;
  job_t              job_in, job_out;
  back_status_t      bstat;
  logic              entry_we, query_we;
  logic [AW-1:0]     entry_waddr, entry_raddr;
  logic [COL_W-1:0]  query_waddr, query_raddr;
  logic [ELEM_W-1:0] entry_wdata, entry_rdata, query_wdata, query_rdata;
  logic [CNT_W-1:0]  count;

  nes_front #(.MAX_ENTRIES(MAX_ENTRIES), .EMBED_DIM(EMBED_DIM)) u_front (
    .clk, .rst_n, .in_push, .in_item, .in_full,
    .job_push, .job(job_in), .job_full, .bstat,
    .entry_we, .entry_waddr, .entry_wdata,
    .query_we, .query_waddr, .query_wdata, .count
  );

  nes_fifo #(.DEPTH(4)) u_fifo (
    .clk, .rst_n, .push(job_push), .din(job_in), .full(job_full),
    .pop(job_pop), .dout(job_out), .empty(job_empty)
  );

  nes_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_ENTRIES * EMBED_DIM)) u_entry_ram (
    .clk, .we(entry_we), .waddr(entry_waddr), .wdata(entry_wdata),
    .raddr(entry_raddr), .rdata(entry_rdata)
  );

  nes_ram #(.WIDTH(ELEM_W), .DEPTH(EMBED_DIM)) u_query_ram (
    .clk, .we(query_we), .waddr(query_waddr), .wdata(query_wdata),
    .raddr(query_raddr), .rdata(query_rdata)
  );

  nes_back #(.MAX_ENTRIES(MAX_ENTRIES), .EMBED_DIM(EMBED_DIM)) u_back (
    .clk, .rst_n, .job_empty, .job(job_out), .job_pop, .count,
    .entry_raddr, .entry_rdata, .query_raddr, .query_rdata,
    .out_item, .out_empty, .out_pop, .bstat
  );

  // The front must never hand a job to a full queue.
  assert property (@(posedge clk) disable iff (!rst_n) job_push |-> !job_full)
    else $error("job queue overflow");

  // The vector memories must not change while a search reads them.
  assert property (@(posedge clk) disable iff (!rst_n)
    (entry_we || query_we) |-> !bstat.busy)
    else $error("memory written during a search");

  // The end of a search shows its match result at once.
  assert property (@(posedge clk) disable iff (!rst_n)
    bstat.search_done |-> (!out_empty && out_item.status == ST_MATCH))
    else $error("search finished without a match result");

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import nes_pkg::*;

  localparam int N_ENTRIES = 64;
  localparam int DIM       = 128;
  localparam logic [DIST_W-1:0] DIST_ONES = '1;

  logic      clk;
  logic      rst_n;
  logic      in_push;
  in_item_t  in_item;
  logic      in_full;
  logic      out_pop;
  out_item_t out_item;
  logic      out_empty;

  nearest_embedding_search #(
    .MAX_ENTRIES(N_ENTRIES),
    .EMBED_DIM  (DIM)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_item  (in_item),
    .in_full  (in_full),
    .out_pop  (out_pop),
    .out_item (out_item),
    .out_empty(out_empty)
  );

  // Shadow copy of the block's state, updated once per accepted request.
  logic signed [ELEM_W-1:0] shadow_entries [N_ENTRIES][DIM];
  logic signed [ELEM_W-1:0] shadow_query [DIM];
  int unsigned shadow_count;
  int unsigned shadow_pos;
  logic [1:0]  shadow_kind;

  // Results still owed by the block, oldest first.
  out_item_t pending_results [$];
  int unsigned mismatches;

  // Sender idling state and the receiver's long hold-off request.
  int  burst_left;
  bit  hold_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Exact sum of squared element differences between the query and one entry,
  // saturated at the square of the distance range.
  function automatic longint unsigned row_sum(input int unsigned row);
    longint unsigned acc;
    longint signed   d;
    longint unsigned m;
    acc = 0;
    for (int j = 0; j < DIM; j++) begin
      d = longint'(shadow_query[j]) - longint'(shadow_entries[row][j]);
      m = (d < 0) ? longint'(-d) : longint'(d);
      if (m >= (64'd1 << DIST_W)) acc = acc + (64'd1 << (2 * DIST_W));
      else acc = acc + m * m;
      if (acc >= (64'd1 << (2 * DIST_W))) acc = 64'd1 << (2 * DIST_W);
    end
    return acc;
  endfunction

  function automatic logic [DIST_W-1:0] root_floor(input longint unsigned n);
    longint unsigned r;
    longint unsigned t;
    if (n >= (64'd1 << (2 * DIST_W))) return DIST_ONES;
    r = 0;
    for (int b = DIST_W - 1; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= n) r = t;
    end
    return r[DIST_W-1:0];
  endfunction

  // Works out the result (if any) that one accepted request causes and
  // advances the shadow state.
  task automatic predict_result(input in_item_t it, output bit has, output out_item_t r);
    int unsigned     best;
    longint unsigned best_sum;
    longint unsigned s;
    has = 1'b0;
    r   = '0;
    if (it.op == OP_CLEAR) begin
      shadow_count = 0;
      shadow_pos   = 0;
      has = 1'b1;
      r.status = ST_CLEARED;
    end else if (it.op == OP_ADD || it.op == OP_QUERY) begin
      if ((shadow_pos != 0 && it.op != shadow_kind) ||
          shadow_pos >= DIM || it.last != (shadow_pos == DIM - 1)) begin
        // Op switch mid-vector, early last or missing last: vector is dropped.
        shadow_pos = 0;
        has = 1'b1;
        r.status = ST_LENERR;
      end else begin
        shadow_kind = it.op;
        if (it.op == OP_ADD) begin
          if (shadow_count < N_ENTRIES)
            shadow_entries[shadow_count][shadow_pos] = it.vector_element;
        end else begin
          shadow_query[shadow_pos] = it.vector_element;
        end
        if (!it.last) begin
          shadow_pos++;
        end else begin
          shadow_pos = 0;
          has = 1'b1;
          if (it.op == OP_ADD) begin
            if (shadow_count >= N_ENTRIES) begin
              r.status = ST_FULL;
            end else begin
              shadow_count++;
              r.status = ST_ADDED;
            end
          end else if (shadow_count == 0) begin
            r.status   = ST_EMPTY;
            r.distance = DIST_ONES;
          end else begin
            best = 0;
            best_sum = row_sum(0);
            for (int unsigned i = 1; i < shadow_count; i++) begin
              s = row_sum(i);
              if (s < best_sum) begin
                best_sum = s;
                best = i;
              end
            end
            r.status      = ST_MATCH;
            r.match_index = best[5:0];
            r.distance    = root_floor(best_sum);
          end
        end
      end
    end
    r.stored_count = shadow_count[6:0];
  endtask

  // Offers one request and waits until the block takes it. The push line is
  // left high afterwards so that a burst runs without bubbles; a gap lowers
  // it on a later falling edge.
  task automatic send_req(input in_item_t it, input bit use_typed, input out_item_t typed);
    bit        has;
    out_item_t r;
    @(negedge clk);
    in_item <= it;
    in_push <= 1'b1;
    do @(posedge clk); while (in_full);
    predict_result(it, has, r);
    if (has) pending_results.push_back(use_typed ? typed : r);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0 && !hold_req) begin
        @(negedge clk);
        in_push <= 1'b0;
        repeat ($urandom_range(0, 8)) @(negedge clk);
      end
    end
  endtask

  task automatic send_elem(input logic [1:0] op, input logic [ELEM_W-1:0] e, input bit last);
    in_item_t it;
    it.op = op;
    it.vector_element = e;
    it.last = last;
    send_req(it, 1'b0, '0);
  endtask

  // A well-formed vector; mode 0 random, 1 constant value, 2 near a stored
  // entry so that queries often land on an exact or close match.
  task automatic send_vector(input logic [1:0] op, input int mode, input logic [ELEM_W-1:0] val);
    int unsigned              row;
    logic [ELEM_W-1:0]        e;
    row = (shadow_count > 0) ? $urandom_range(0, shadow_count - 1) : 0;
    for (int j = 0; j < DIM; j++) begin
      case (mode)
        0: e = $urandom;
        1: e = val;
        default: begin
          e = shadow_entries[row][j];
          if ($urandom_range(0, 3) == 0) e = e + $urandom_range(0, 64) - 32;
        end
      endcase
      send_elem(op, e, j == DIM - 1);
    end
  endtask

  // Receiver: random stall pattern whose density changes every so often,
  // plus a long counted hold-off on request.
  initial begin
    int mode;
    int left;
    int hold_cnt;
    out_pop  = 1'b0;
    mode     = 0;
    left     = 0;
    hold_cnt = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = $urandom_range(50, 300);
      end
      left--;
      if (hold_req && hold_cnt < 400) begin
        hold_cnt++;
        out_pop <= 1'b0;
      end else begin
        if (!hold_req) hold_cnt = 0;
        case (mode)
          0: out_pop <= 1'b1;
          1: out_pop <= ($urandom_range(0, 3) != 0);
          default: out_pop <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // Result checker: compares every accepted result with the oldest one owed.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d index %0d distance %0d count %0d",
                   out_item.status, out_item.match_index, out_item.distance,
                   out_item.stored_count);
      end else begin
        want = pending_results.pop_front();
        if (out_item.status !== want.status || out_item.match_index !== want.match_index ||
            out_item.distance !== want.distance ||
            out_item.stored_count !== want.stored_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                     want.status, want.match_index, want.distance, want.stored_count,
                     out_item.status, out_item.match_index, out_item.distance,
                     out_item.stored_count);
        end
      end
    end
  end

  // Directed table: short sequences around the protocol corners. Rows whose
  // outcome is obvious carry their result; the rest go through the predictor.
  typedef struct {
    in_item_t  it;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  stim_row_t dir_rows [] = '{
    // Query with last on its first element: length error on an empty store.
    '{'{OP_QUERY, 16'sh7fff, 1'b1}, 1'b1, '{ST_LENERR, 6'd0, 20'd0, 7'd0}},
    '{'{OP_ADD, 16'sh8000, 1'b0}, 1'b0, '0},
    // Op switches mid-vector: the partial add is discarded.
    '{'{OP_QUERY, 16'sh0001, 1'b0}, 1'b1, '{ST_LENERR, 6'd0, 20'd0, 7'd0}},
    // The unused op value is ignored entirely.
    '{'{2'd3, 16'shffff, 1'b1}, 1'b0, '0},
    '{'{OP_CLEAR, 16'sh0000, 1'b0}, 1'b1, '{ST_CLEARED, 6'd0, 20'd0, 7'd0}},
    '{'{OP_ADD, 16'sh7fff, 1'b1}, 1'b1, '{ST_LENERR, 6'd0, 20'd0, 7'd0}},
    '{'{OP_ADD, 16'sh8000, 1'b0}, 1'b0, '0},
    '{'{OP_ADD, 16'sh5555, 1'b0}, 1'b0, '0},
    // Clear drops the vector in progress and ignores its own last flag.
    '{'{OP_CLEAR, 16'sh7fff, 1'b1}, 1'b1, '{ST_CLEARED, 6'd0, 20'd0, 7'd0}},
    '{'{2'd3, 16'sh0000, 1'b0}, 1'b0, '0}
  };

  initial begin
    int n_items;
    int pick;
    int cut;
    rst_n      = 1'b0;
    in_push    = 1'b0;
    in_item    = '0;
    hold_req   = 1'b0;
    mismatches = 0;
    burst_left = 1;
    shadow_count = 0;
    shadow_pos   = 0;
    shadow_kind  = OP_ADD;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_req(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);

    // Query on an empty store, then extreme entries and queries against them.
    send_vector(OP_QUERY, 1, 16'h0000);
    send_vector(OP_ADD, 1, 16'h7fff);
    send_vector(OP_ADD, 1, 16'h8000);
    send_vector(OP_ADD, 1, 16'h0000);
    send_vector(OP_QUERY, 1, 16'h8000);
    send_vector(OP_QUERY, 1, 16'h7fff);
    send_vector(OP_QUERY, 1, 16'h0001);
    send_vector(OP_QUERY, 0, '0);
    // Missing last flag on the final element.
    for (int j = 0; j < DIM; j++) send_elem(OP_ADD, $urandom, 1'b0);

    // Hold the receiver off while short erroring requests pile up.
    hold_req = 1'b1;
    for (int k = 0; k < 16; k++) send_elem(OP_ADD, $urandom, 1'b1);
    hold_req = 1'b0;

    // Fill the store, add once more to hit the full case, query the full store.
    while (shadow_count < N_ENTRIES) send_vector(OP_ADD, 0, '0);
    send_vector(OP_ADD, 0, '0);
    send_vector(OP_QUERY, 2, '0);
    send_vector(OP_QUERY, 0, '0);
    send_elem(OP_CLEAR, '0, 1'b0);

    // Random part: mostly well-formed vectors with random content, some
    // broken vectors, clears and ignored ops.
    n_items = 0;
    while (n_items < 1000) begin
      pick = $urandom_range(0, 99);
      if (pick < 45 && shadow_count < 12) begin
        send_vector(OP_ADD, 0, '0);
        n_items += DIM;
      end else if (pick < 70) begin
        send_vector(OP_QUERY, (shadow_count > 0 && pick < 60) ? 2 : 0, '0);
        n_items += DIM;
      end else if (pick < 88) begin
        // Broken vector: early last, or an op switch partway through.
        cut = $urandom_range(0, DIM - 2);
        for (int j = 0; j < cut; j++) send_elem(pick[0] ? OP_QUERY : OP_ADD, $urandom, 1'b0);
        if (pick < 80) send_elem(pick[0] ? OP_QUERY : OP_ADD, $urandom, 1'b1);
        else send_elem(pick[0] ? OP_ADD : OP_QUERY, $urandom, $urandom_range(0, 1));
        n_items += cut + 1;
      end else if (pick < 94) begin
        send_elem(OP_CLEAR, $urandom, $urandom_range(0, 1));
        n_items++;
      end else begin
        send_elem(2'd3, $urandom, $urandom_range(0, 1));
      end
    end

    @(negedge clk);
    in_push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("nearest_embedding_search regression: pass");
    end else begin
      $display("nearest_embedding_search regression: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run, full-store queries included.
  initial begin
    #40ms;
    $display("nearest_embedding_search regression: fail");
    $finish;
  end

endmodule
